// ===== rtl/core/gh_pkg.sv =====
// ----------------------------------------------------------------------------
// Geohash encoder package
// Shared widths, range constants, the base32 alphabet and the command bundle
// from the controller to the datapath.
// ----------------------------------------------------------------------------
package gh_pkg;

  localparam int MAX_SYMBOLS         = 12;
  localparam int COORD_FRACTION_BITS = 24;
  localparam int EXTRA_BITS          = 4;
  localparam int RANGE_SHIFT         = COORD_FRACTION_BITS + EXTRA_BITS;

  localparam int LAT_W    = 32;
  localparam int LON_W    = 33;
  localparam int COUNT_W  = 4;
  localparam int CODE_W   = 5;
  localparam int CHAR_W   = 7;

  localparam int BITS_PER_SYMBOL = CODE_W;
  localparam int BIT_CNT_W       = $clog2(BITS_PER_SYMBOL);
  localparam int LEFT_W          = $clog2(MAX_SYMBOLS + 1);

  localparam int RANGE_W = (COORD_FRACTION_BITS + 16 > LON_W + EXTRA_BITS) ?
                           COORD_FRACTION_BITS + 16 : LON_W + EXTRA_BITS + 1;

  localparam logic signed [RANGE_W-1:0] LON_HIGH_INIT =
    RANGE_W'(longint'(180) <<< RANGE_SHIFT);
  localparam logic signed [RANGE_W-1:0] LON_LOW_INIT  =
    RANGE_W'(-(longint'(180) <<< RANGE_SHIFT));
  localparam logic signed [RANGE_W-1:0] LAT_HIGH_INIT =
    RANGE_W'(longint'(90) <<< RANGE_SHIFT);
  localparam logic signed [RANGE_W-1:0] LAT_LOW_INIT  =
    RANGE_W'(-(longint'(90) <<< RANGE_SHIFT));

  localparam logic [CHAR_W-1:0] ALPHABET [2**CODE_W] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
  };

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic last;
  } gh_cmd_t;

endpackage

// ===== rtl/core/geohash_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Geohash encoder core
// Turns one latitude and longitude pair into a stream of base32 geohash
// symbols.
// ----------------------------------------------------------------------------
// Each input transfer carries a coordinate pair in units of 2^-24 degree and
// a symbol count, which is saturated at twelve; a count of zero produces no
// output. The core works on one coordinate pair at a time: it loads the item
// and then performs five bisections per symbol, and takes no new item until
// the last symbol of the current one is emitted. The single shared bisection
// unit, one 41-bit add and compare, performs one bisection per cycle except
// while a finished symbol waits for the output register to be free. Symbols
// leave through an output register, so a new coordinate is accepted while the
// last symbol of the previous one still waits for its output transfer.
// ----------------------------------------------------------------------------
module geohash_encoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gh_pkg::LAT_W-1:0]   latitude_i,
  input  logic signed [gh_pkg::LON_W-1:0]   longitude_i,
  input  logic [gh_pkg::COUNT_W-1:0]        symbol_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gh_pkg::CODE_W-1:0]         symbol_code_o,
  output logic [gh_pkg::CHAR_W-1:0]         symbol_char_o,
  output logic                              is_last_o
);
  import gh_pkg::*;

  gh_cmd_t cmd;

  gh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .symbol_count_i (symbol_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd)
  );

  gh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .symbol_code_o (symbol_code_o),
    .symbol_char_o (symbol_char_o),
    .is_last_o     (is_last_o)
  );

  a_emit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> cmd.step && !cmd.load)
    else $error("symbol emitted without a bisection step");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid rose without an emitted symbol");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> in_ready_o)
    else $error("core not ready after the last symbol of an item");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready_o)
    else $error("bisection step while accepting a new coordinate");

endmodule

// ===== rtl/core/gh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Geohash encoder controller
// Accepts coordinate transfers, sequences the bisections of each symbol and
// pushes finished symbols into the output register when it is free.
// ----------------------------------------------------------------------------
module gh_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gh_pkg::COUNT_W-1:0]   symbol_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gh_pkg::gh_cmd_t              cmd_o
);
  import gh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_BISECT = 2'b10
  } gh_state_e;

  gh_state_e             state_q, state_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [LEFT_W-1:0]     left_q, left_d;
  logic                  out_valid_q, out_valid_d;
  logic [LEFT_W-1:0]     count_sat;
  logic                  can_emit;
  logic                  last_bit;

  assign count_sat = (int'(symbol_count_i) > MAX_SYMBOLS) ? LEFT_W'(MAX_SYMBOLS)
                                                          : LEFT_W'(symbol_count_i);
  assign can_emit  = !out_valid_q || out_ready_i;
  assign last_bit  = (bit_cnt_q == BIT_CNT_W'(BITS_PER_SYMBOL - 1));

  always_comb begin
    state_d    = state_q;
    bit_cnt_d  = bit_cnt_q;
    left_d     = left_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          left_d     = count_sat;
          bit_cnt_d  = '0;
          if (count_sat != '0) begin
            state_d = S_BISECT;
          end
        end
      end
      S_BISECT: begin
        if (!last_bit) begin
          cmd_o.step = 1'b1;
          bit_cnt_d  = bit_cnt_q + 1'b1;
        end else if (can_emit) begin
          cmd_o.step = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.last = (left_q == LEFT_W'(1));
          bit_cnt_d  = '0;
          left_d     = left_q - 1'b1;
          if (left_q == LEFT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/gh_datapath.sv =====
// ----------------------------------------------------------------------------
// Geohash encoder datapath
// Holds the coordinate and both ranges, performs one bisection per step on
// the coordinate whose turn it is, and keeps the output symbol register.
// ----------------------------------------------------------------------------
module gh_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gh_pkg::gh_cmd_t                   cmd_i,
  input  logic signed [gh_pkg::LAT_W-1:0]   latitude_i,
  input  logic signed [gh_pkg::LON_W-1:0]   longitude_i,
  output logic [gh_pkg::CODE_W-1:0]         symbol_code_o,
  output logic [gh_pkg::CHAR_W-1:0]         symbol_char_o,
  output logic                              is_last_o
);
  import gh_pkg::*;

  logic signed [RANGE_W-1:0] lon_low_q, lon_high_q, lat_low_q, lat_high_q;
  logic signed [LAT_W-1:0]   held_lat_q;
  logic signed [LON_W-1:0]   held_lon_q;
  logic                      lon_turn_q;
  logic [CODE_W-2:0]         code_q;
  logic [CODE_W-1:0]         out_code_q;
  logic [CHAR_W-1:0]         out_char_q;
  logic                      out_last_q;

  logic signed [RANGE_W-1:0] lat_val, lon_val, sel_val, sel_low, sel_high, mid;
  logic [RANGE_W:0]          mid_sum;
  logic                      decision;
  logic [CODE_W-1:0]         code_next;

  assign lat_val = {{(RANGE_W - LAT_W - EXTRA_BITS){held_lat_q[LAT_W-1]}},
                    held_lat_q, {EXTRA_BITS{1'b0}}};
  assign lon_val = {{(RANGE_W - LON_W - EXTRA_BITS){held_lon_q[LON_W-1]}},
                    held_lon_q, {EXTRA_BITS{1'b0}}};

  assign sel_val  = lon_turn_q ? lon_val    : lat_val;
  assign sel_low  = lon_turn_q ? lon_low_q  : lat_low_q;
  assign sel_high = lon_turn_q ? lon_high_q : lat_high_q;

  assign mid_sum   = {sel_low[RANGE_W-1], sel_low} + {sel_high[RANGE_W-1], sel_high};
  assign mid       = mid_sum[RANGE_W:1];
  assign decision  = (sel_val >= mid);
  assign code_next = {code_q, decision};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_lat_q <= latitude_i;
      held_lon_q <= longitude_i;
      lon_low_q  <= LON_LOW_INIT;
      lon_high_q <= LON_HIGH_INIT;
      lat_low_q  <= LAT_LOW_INIT;
      lat_high_q <= LAT_HIGH_INIT;
    end else if (cmd_i.step) begin
      code_q <= code_next[CODE_W-2:0];
      if (lon_turn_q) begin
        if (decision) begin
          lon_low_q <= mid;
        end else begin
          lon_high_q <= mid;
        end
      end else begin
        if (decision) begin
          lat_low_q <= mid;
        end else begin
          lat_high_q <= mid;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_turn_q <= 1'b1;
    end else if (cmd_i.load) begin
      lon_turn_q <= 1'b1;
    end else if (cmd_i.step) begin
      lon_turn_q <= !lon_turn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_code_q <= code_next;
      out_char_q <= ALPHABET[code_next];
      out_last_q <= cmd_i.last;
    end
  end

  assign symbol_code_o = out_code_q;
  assign symbol_char_o = out_char_q;
  assign is_last_o     = out_last_q;

endmodule
